FILE: rtl/afr_pkg.sv
`default_nettype none

package afr_pkg;

    localparam int unsigned MAX_FRAME = 77;
    localparam int unsigned MIN_FRAME = 11;

    localparam logic [7:0]  START_CHAR = 8'h21;   // '!'
    localparam logic [7:0]  END_CHAR   = 8'h3B;   // ';'
    localparam logic [7:0]  DIGIT_LO   = 8'h30;   // '0'
    localparam logic [7:0]  DIGIT_HI   = 8'h39;   // '9'

    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [23:0] OWN_ADDRESS_RESET = 24'h53544D;

    localparam int unsigned LEN_W  = 7;
    localparam int unsigned SUM_W  = 17;
    localparam int unsigned ADDR_W = 24;

    // frame offsets
    localparam logic [LEN_W-1:0] POS_DST0  = LEN_W'(3);
    localparam logic [LEN_W-1:0] POS_DST1  = LEN_W'(4);
    localparam logic [LEN_W-1:0] POS_DST2  = LEN_W'(5);
    localparam logic [LEN_W-1:0] POS_CMD   = LEN_W'(MIN_FRAME);
    localparam logic [LEN_W-1:0] POS_LAST  = LEN_W'(MAX_FRAME - 1);

    typedef enum logic [1:0] {
        KIND_CMD_BYTE = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_CRC_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0]        computed_crc;
        logic [LEN_W-1:0]   cmd_length;
        logic [ADDR_W-1:0]  src_address;
        logic [LEN_W-1:0]   byte_index;
        logic [7:0]         cmd_byte;
    } result_t;

    // CRC-16/MODBUS, one byte, reflected, bit at a time
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ascii_frame_receiver_crc16_check.sv
`default_nettype none

// ASCII frame receiver with CRC-16/MODBUS check.
// Slave stream (s_*): one received character per word in s_tdata[7:0].
// Master stream (m_*): at most one result word per input word. m_tuser holds
//   the kind (tentative command byte, frame accepted, checksum error); m_tdata
//   holds the command byte, its index, source address, command length and CRC.
// Frames are '!' SRC(3) DST(3) SUM(5 decimal digits) CMD ';'. Only frames
// addressed to own_address produce results; command bytes come out as they
// arrive, and ';' gives the verdict.
// A result is registered: it is on m_* in the cycle after its input word is taken.
// Throughput: one word per cycle unless a result waits on m_tready; the byte CRC
// update and the frame state update sit between the input handshake and the result register.
// Stall: while a result waits on m_tready low, s_tready drops; it rises again
// in the same cycle that the waiting result is taken.
// Reset (rst_n low, asynchronous): no frame open, CRC at 0xFFFF, result
// register empty, own_address back to its reset value. cfg_wr_en/cfg_wr_data write
// own_address; the user writes only while the block is idle; the block does not enforce it.
module ascii_frame_receiver_crc16_check (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_wr_en,
    input  wire logic [afr_pkg::ADDR_W-1:0]  cfg_wr_data,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [63:0]                      m_tdata,   // [7:0] cmd_byte, [14:8] byte_index,
                                                        // [38:15] src_address,
                                                        // [45:39] cmd_length,
                                                        // [61:46] computed_crc, [63:62] zero
    output logic [1:0]                       m_tuser    // [1:0] kind
);
    import afr_pkg::*;

    // configuration
    logic [ADDR_W-1:0] own_address_reg;

    // frame state
    logic              in_frame_reg,       in_frame_next;
    logic [LEN_W-1:0]  frame_length_reg,   frame_length_next;
    logic [15:0]       running_crc_reg,    running_crc_next;
    logic [SUM_W-1:0]  given_checksum_reg, given_checksum_next;
    logic              digits_stopped_reg, digits_stopped_next;
    logic [ADDR_W-1:0] sender_address_reg, sender_address_next;
    logic              address_match_reg,  address_match_next;

    // result register
    logic              out_valid_reg,      out_valid_next;
    kind_t             out_kind_reg,       out_kind_next;
    result_t           out_data_reg,       out_data_next;

    logic              accept;
    logic              emit;
    logic [7:0]        rx;
    logic [15:0]       crc_upd;
    logic [7:0]        want_byte;
    logic              is_digit;
    logic [SUM_W+3:0]  sum_times10;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign rx       = s_tdata;

    assign crc_upd  = crc16_byte(running_crc_reg, rx);
    assign is_digit = (rx >= DIGIT_LO) && (rx <= DIGIT_HI);
    // x*10 = x*8 + x*2, then the digit; kept to 17 bits
    assign sum_times10 = {1'b0, given_checksum_reg, 3'b000}
                       + {3'b000, given_checksum_reg, 1'b0}
                       + {(SUM_W)'(0), 4'(rx - DIGIT_LO)};

    always_comb
    begin
        unique case (frame_length_reg)
            POS_DST0: want_byte = own_address_reg[23:16];
            POS_DST1: want_byte = own_address_reg[15:8];
            POS_DST2: want_byte = own_address_reg[7:0];
            default:  want_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        in_frame_next       = in_frame_reg;
        frame_length_next   = frame_length_reg;
        running_crc_next    = running_crc_reg;
        given_checksum_next = given_checksum_reg;
        digits_stopped_next = digits_stopped_reg;
        sender_address_next = sender_address_reg;
        address_match_next  = address_match_reg;
        emit                = 1'b0;
        out_kind_next       = out_kind_reg;
        out_data_next       = out_data_reg;

        if (accept)
        begin
            if (rx == START_CHAR)
            begin
                // '!' always opens a fresh frame
                in_frame_next       = 1'b1;
                frame_length_next   = '0;
                running_crc_next    = CRC_SEED;
                given_checksum_next = '0;
                digits_stopped_next = 1'b0;
                sender_address_next = '0;
                address_match_next  = 1'b0;
            end
            else if (in_frame_reg)
            begin
                if (rx == END_CHAR)
                begin
                    if ((frame_length_reg >= POS_CMD) && address_match_reg)
                    begin
                        emit          = 1'b1;
                        out_kind_next = (given_checksum_reg == {1'b0, running_crc_reg})
                                      ? KIND_ACCEPTED : KIND_CRC_ERR;
                        out_data_next.cmd_byte     = '0;
                        out_data_next.byte_index   = '0;
                        out_data_next.src_address  = sender_address_reg;
                        out_data_next.cmd_length   = frame_length_reg - POS_CMD;
                        out_data_next.computed_crc = running_crc_reg;
                    end
                    in_frame_next     = 1'b0;
                    frame_length_next = '0;
                end
                else if (frame_length_reg >= POS_LAST)
                begin
                    // overlong frame: dropped without a word
                    in_frame_next     = 1'b0;
                    frame_length_next = '0;
                end
                else
                begin
                    frame_length_next = frame_length_reg + LEN_W'(1);
                    if (frame_length_reg < POS_DST0)
                    begin
                        sender_address_next = {sender_address_reg[ADDR_W-9:0], rx};
                        running_crc_next    = crc_upd;
                    end
                    else if (frame_length_reg < POS_DST2 + LEN_W'(1))
                    begin
                        if (frame_length_reg == POS_DST0)
                            address_match_next = (rx == want_byte);
                        else
                            address_match_next = address_match_reg && (rx == want_byte);
                        running_crc_next = crc_upd;
                    end
                    else if (frame_length_reg < POS_CMD)
                    begin
                        if (!digits_stopped_reg && is_digit)
                            given_checksum_next = sum_times10[SUM_W-1:0];
                        else
                            digits_stopped_next = 1'b1;
                    end
                    else
                    begin
                        running_crc_next = crc_upd;
                        if (address_match_reg)
                        begin
                            emit          = 1'b1;
                            out_kind_next = KIND_CMD_BYTE;
                            out_data_next.cmd_byte     = rx;
                            out_data_next.byte_index   = frame_length_reg - POS_CMD;
                            out_data_next.src_address  = '0;
                            out_data_next.cmd_length   = '0;
                            out_data_next.computed_crc = '0;
                        end
                    end
                end
            end
        end

        out_valid_next = (out_valid_reg && !m_tready) || emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg    <= OWN_ADDRESS_RESET;
            in_frame_reg       <= 1'b0;
            frame_length_reg   <= '0;
            running_crc_reg    <= CRC_SEED;
            given_checksum_reg <= '0;
            digits_stopped_reg <= 1'b0;
            sender_address_reg <= '0;
            address_match_reg  <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                own_address_reg <= cfg_wr_data;
            in_frame_reg       <= in_frame_next;
            frame_length_reg   <= frame_length_next;
            running_crc_reg    <= running_crc_next;
            given_checksum_reg <= given_checksum_next;
            digits_stopped_reg <= digits_stopped_next;
            sender_address_reg <= sender_address_next;
            address_match_reg  <= address_match_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

`default_nettype wire

FILE: tb/tb_ascii_frame_receiver_crc16_check.sv
`timescale 1ns / 1ps

// Bench for the checked-frame receiver.
// A queue of pending bytes is filled by the sequencer (initial block below) one
// phase at a time. The driver pushes them into the slave stream in random bursts.
// Every byte taken there runs through the bench's own model of the receiver,
// which queues the result words the block should emit. The monitor pops one
// expectation per result word taken on the master stream and compares it field
// by field. own_address is only rewritten once both streams have drained.
module tb_ascii_frame_receiver_crc16_check;

    import afr_pkg::*;

    // one expected or observed result word: kind from tuser, the rest from tdata
    typedef struct packed {
        kind_t   kind;
        result_t body;
    } frame_event_t;

    // how the five checksum characters of a generated frame are filled in
    typedef enum int {
        SUM_EXACT,        // CRC as five digits, zero padded
        SUM_UNPADDED,     // CRC digits, then a non-digit stops the scan
        SUM_OFF_BY_ONE,   // CRC + 1, five digits
        SUM_GARBAGE,      // five random characters
        SUM_TOO_BIG       // 65536 or more, can never match
    } sum_style_t;

    localparam int FIELD_COUNT = 6;

    string field_label [0:FIELD_COUNT-1] = '{"kind", "cmd_byte", "byte_index",
                                             "src_address", "cmd_length",
                                             "computed_crc"};

    // clock, reset and block inputs, all known from time zero
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [23:0] cfg_wr_data = 24'h000000;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = 8'h00;
    logic        m_tready    = 1'b0;

    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire  [1:0]  m_tuser;

    // stimulus and scoreboard storage
    logic [7:0]   rx_backlog [$];          // bytes still to be offered
    frame_event_t frame_events_due [$];    // results predicted, not yet seen
    int           bytes_queued = 0;
    int           mismatches   = 0;

    // sender burst shaping and receiver stall pattern
    int burst_left  = 0;
    int gap_left    = 0;
    int stall_style = 0;
    int style_left  = 0;

    // receiver model state
    logic        frame_open = 1'b0;
    logic [6:0]  stored_len = '0;
    logic [15:0] crc_acc    = CRC_SEED;
    logic [16:0] sum_value  = '0;
    logic        sum_done   = 1'b0;
    logic [23:0] src_addr   = '0;
    logic        dst_ok     = 1'b0;
    logic [23:0] my_address = OWN_ADDRESS_RESET;

    ascii_frame_receiver_crc16_check u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Model of the receiver
    // ---------------------------------------------------------------------

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc,
                                                      input logic [7:0]  b);
        logic [15:0] r;
        int          i;
        r = acc ^ {8'h00, b};
        for (i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // one accepted input byte; queues whatever result word it should cause
    function automatic void receive_byte(input logic [7:0] b);
        int           pos;
        logic [7:0]   want;
        frame_event_t ev;
        ev = '0;
        if (b == START_CHAR)
        begin
            // '!' always opens a fresh frame, dropping any half-received one
            frame_open = 1'b1;
            stored_len = '0;
            crc_acc    = CRC_SEED;
            sum_value  = '0;
            sum_done   = 1'b0;
            src_addr   = '0;
            dst_ok     = 1'b0;
        end
        else if (frame_open)
        begin
            if (b == END_CHAR)
            begin
                // verdict only for frames long enough and addressed to us
                if (stored_len >= MIN_FRAME && dst_ok)
                begin
                    ev.kind = (sum_value == {1'b0, crc_acc}) ? KIND_ACCEPTED
                                                             : KIND_CRC_ERR;
                    ev.body.src_address  = src_addr;
                    ev.body.cmd_length   = 7'(stored_len - MIN_FRAME);
                    ev.body.computed_crc = crc_acc;
                    frame_events_due.push_back(ev);
                end
                frame_open = 1'b0;
                stored_len = '0;
            end
            else
            begin
                pos        = stored_len;
                stored_len = stored_len + 7'd1;
                if (pos + 1 >= MAX_FRAME)
                begin
                    // frame full: dropped without a word
                    frame_open = 1'b0;
                    stored_len = '0;
                end
                else if (pos < 3)
                begin
                    src_addr = {src_addr[15:0], b};
                    crc_acc  = crc16_modbus_step(crc_acc, b);
                end
                else if (pos < 6)
                begin
                    want    = my_address[8*(5-pos) +: 8];
                    dst_ok  = (pos == 3) ? (b == want) : (dst_ok && b == want);
                    crc_acc = crc16_modbus_step(crc_acc, b);
                end
                else if (pos < MIN_FRAME)
                begin
                    // decimal checksum, scan stops at the first non-digit
                    if (!sum_done && b >= DIGIT_LO && b <= DIGIT_HI)
                        sum_value = 17'(sum_value * 10 + (b - DIGIT_LO));
                    else
                        sum_done = 1'b1;
                end
                else
                begin
                    crc_acc = crc16_modbus_step(crc_acc, b);
                    if (dst_ok)
                    begin
                        ev.kind            = KIND_CMD_BYTE;
                        ev.body.cmd_byte   = b;
                        ev.body.byte_index = 7'(pos - MIN_FRAME);
                        frame_events_due.push_back(ev);
                    end
                end
            end
        end
    endfunction

    function automatic logic [23:0] event_field(input frame_event_t e, input int f);
        case (f)
            0:       return 24'(e.kind);
            1:       return 24'(e.body.cmd_byte);
            2:       return 24'(e.body.byte_index);
            3:       return e.body.src_address;
            4:       return 24'(e.body.cmd_length);
            default: return 24'(e.body.computed_crc);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Driver: bursts of random length, random gaps between them
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                receive_byte(s_tdata);
            // slot free: either idle or the current word has just gone
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || rx_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tdata  <= rx_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each result word taken; tready follows its own pattern
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        frame_event_t want;
        frame_event_t got;
        int           f;
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_style = 0;
            style_left  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind = kind_t'(m_tuser);
                got.body = result_t'(m_tdata[61:0]);
                if (m_tdata[63:62] !== 2'b00)
                begin
                    $display("%0t: tdata pad expected 0, got %b", $time, m_tdata[63:62]);
                    mismatches++;
                end
                if (frame_events_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected nothing, got kind %0d tdata %h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = frame_events_due.pop_front();
                    for (f = 0; f < FIELD_COUNT; f++)
                        if (event_field(want, f) !== event_field(got, f))
                        begin
                            $display("%0t: %s expected %0h, got %0h", $time,
                                     field_label[f], event_field(want, f),
                                     event_field(got, f));
                            mismatches++;
                        end
                end
            end
            // pick a new stall style whenever style_left has run down to zero
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(16, 96);
            end
            else
                style_left--;
            case (stall_style)
                0:       m_tready <= 1'b1;                          // no back-pressure
                1:       m_tready <= 1'($urandom_range(0, 1));      // coin toss
                2:       m_tready <= ($urandom_range(0, 4) != 0);   // light stalls
                default: m_tready <= ($urandom_range(0, 7) == 0);   // heavy stalls
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    // any byte that cannot open or close a frame, optionally no digit either
    function automatic logic [7:0] frame_safe_byte(input bit no_digit);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == START_CHAR || b == END_CHAR || (no_digit && b >= DIGIT_LO && b <= DIGIT_HI))
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [23:0] random_address();
        return {frame_safe_byte(1'b0), frame_safe_byte(1'b0), frame_safe_byte(1'b0)};
    endfunction

    // k-th of five decimal digits of value, most significant first
    function automatic logic [7:0] digit_char(input int value, input int k);
        int scale;
        scale = 1;
        repeat (4 - k)
            scale *= 10;
        return DIGIT_LO + 8'((value / scale) % 10);
    endfunction

    function automatic sum_style_t pick_sum_style();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return SUM_EXACT;
        else if (r < 60)
            return SUM_UNPADDED;
        else if (r < 75)
            return SUM_OFF_BY_ONE;
        else if (r < 90)
            return SUM_GARBAGE;
        return SUM_TOO_BIG;
    endfunction

    // '!' src dst checksum command [';']
    task automatic add_frame(input logic [23:0] src, input logic [23:0] dst,
                             input int n_cmd, input sum_style_t style, input bit closed);
        logic [7:0]  cmd [$];
        logic [15:0] crc;
        int          value;
        int          nd;
        int          i;
        crc = CRC_SEED;
        for (i = 2; i >= 0; i--)
            crc = crc16_modbus_step(crc, src[8*i +: 8]);
        for (i = 2; i >= 0; i--)
            crc = crc16_modbus_step(crc, dst[8*i +: 8]);
        for (i = 0; i < n_cmd; i++)
        begin
            cmd.push_back(frame_safe_byte(1'b0));
            crc = crc16_modbus_step(crc, cmd[i]);
        end
        push_byte(START_CHAR);
        for (i = 2; i >= 0; i--)
            push_byte(src[8*i +: 8]);
        for (i = 2; i >= 0; i--)
            push_byte(dst[8*i +: 8]);
        case (style)
            SUM_UNPADDED:
            begin
                value = crc;
                nd    = 1;
                while (value >= 10)
                begin
                    value /= 10;
                    nd++;
                end
                for (i = 5 - nd; i < 5; i++)
                    push_byte(digit_char(crc, i));
                if (nd < 5)
                begin
                    push_byte(frame_safe_byte(1'b1));
                    repeat (4 - nd)
                        push_byte(frame_safe_byte(1'b0));
                end
            end
            SUM_GARBAGE:
                repeat (5)
                    push_byte(frame_safe_byte(1'b0));
            default:
            begin
                if (style == SUM_OFF_BY_ONE)
                    value = (crc + 1) % 65536;
                else if (style == SUM_TOO_BIG)
                    value = 65536 + $urandom_range(0, 34463);
                else
                    value = crc;
                for (i = 0; i < 5; i++)
                    push_byte(digit_char(value, i));
            end
        endcase
        foreach (cmd[j])
            push_byte(cmd[j]);
        if (closed)
            push_byte(END_CHAR);
    endtask

    // fewer than eleven stored bytes between '!' and ';'
    task automatic add_short_frame(input int n);
        push_byte(START_CHAR);
        repeat (n)
            push_byte(frame_safe_byte(1'b0));
        push_byte(END_CHAR);
    endtask

    // own address with one byte changed
    function automatic logic [23:0] near_miss_address();
        logic [23:0] dst;
        logic [7:0]  b;
        int          lane;
        dst  = my_address;
        lane = $urandom_range(0, 2);
        b    = frame_safe_byte(1'b0);
        while (b == dst[8*lane +: 8])
            b = frame_safe_byte(1'b0);
        dst[8*lane +: 8] = b;
        return dst;
    endfunction

    // mostly well-formed frames to us, then foreign, short, and line noise
    task automatic add_random_traffic(input int budget);
        int start;
        int r;
        int n;
        start = bytes_queued;
        while (bytes_queued - start < budget)
        begin
            r = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 70) : $urandom_range(0, 8);
            if (r < 60)
                add_frame(random_address(), my_address, n, pick_sum_style(),
                          $urandom_range(0, 9) != 0);
            else if (r < 75)
                add_frame(random_address(), near_miss_address(), n, pick_sum_style(), 1'b1);
            else if (r < 85)
                add_short_frame($urandom_range(0, 10));
            else
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // hold off until every byte is in and every predicted word is out
    task automatic settle();
        int waited;
        waited = 0;
        while (rx_backlog.size() != 0 || s_tvalid)
            @(negedge clk);
        while (frame_events_due.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        if (frame_events_due.size() != 0)
        begin
            $display("%0t: %0d result words expected, got none of them", $time,
                     frame_events_due.size());
            mismatches += frame_events_due.size();
            frame_events_due.delete();
        end
        // spare wait for bytes that give no word
        repeat (3)
            @(negedge clk);
    endtask

    task automatic write_own_address(input logic [23:0] addr);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        my_address  = addr;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 0: address left at its reset value
        push_byte(8'h00);                       // stray bytes outside a frame
        push_byte(8'hFF);
        push_byte(END_CHAR);
        push_byte(8'h55);
        add_frame(random_address(), my_address, 0, SUM_EXACT, 1'b1);     // empty command
        add_frame(24'hFFFFFF, my_address, 3, SUM_EXACT, 1'b1);
        add_frame(24'h000000, my_address, 2, SUM_UNPADDED, 1'b1);        // checksum digits not zero padded
        add_frame(random_address(), my_address, 1, SUM_OFF_BY_ONE, 1'b1);
        add_frame(random_address(), my_address, 2, SUM_GARBAGE, 1'b1);
        add_frame(random_address(), my_address, 0, SUM_TOO_BIG, 1'b1);
        add_frame(random_address(), {my_address[23:8], my_address[7:0] ^ 8'h01}, 3,
                  SUM_EXACT, 1'b1);                                       // foreign dst
        add_short_frame(10);                                              // one short
        add_short_frame(0);
        add_frame(random_address(), my_address, 65, SUM_EXACT, 1'b1);    // longest kept
        add_frame(random_address(), my_address, 66, SUM_EXACT, 1'b1);    // overflows
        add_frame(random_address(), my_address, 4, SUM_EXACT, 1'b0);     // cut by next '!'
        add_frame(random_address(), my_address, 1, SUM_EXACT, 1'b1);
        add_random_traffic(36);
        settle();

        // phase 1: all-zero address, zero bytes must compare like any other
        write_own_address(24'h000000);
        add_frame(random_address(), 24'h000000, 2, SUM_EXACT, 1'b1);
        add_frame(random_address(), 24'h000100, 1, SUM_EXACT, 1'b1);
        add_random_traffic(36);
        settle();

        write_own_address(24'hFFFFFF);
        add_random_traffic(36);
        settle();

        write_own_address(random_address());
        add_random_traffic(36);
        settle();

        write_own_address(OWN_ADDRESS_RESET);
        add_random_traffic(36);
        settle();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: ascii_frame_receiver_crc16_check.f
rtl/afr_pkg.sv
rtl/ascii_frame_receiver_crc16_check.sv
tb/tb_ascii_frame_receiver_crc16_check.sv
